@@ rtl/pru_pkg.sv @@
// Shared types, codes and constants for the PNG row unfilter block.
package pru_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W    = 12;
	localparam int LANES      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 1'd1;

	localparam logic [7:0] OPAQUE = 8'd255;

	typedef logic [7:0] byte_t;
	typedef logic [LANES-1:0][7:0] pix_t;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	typedef enum logic [1:0] {
		MODE_GRAY       = 2'd0,
		MODE_GRAY_ALPHA = 2'd1,
		MODE_RGB        = 2'd2,
		MODE_RGBA       = 2'd3
	} mode_t;

	// neighbours handed to one channel lane
	typedef struct packed {
		byte_t left;
		byte_t up;
		byte_t upleft;
	} nbr_t;

endpackage

@@ rtl/pru_if.sv @@
// Valid/ready channels for filtered pixels in and RGBA pixels out.
interface pru_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] row_filter;
	logic [7:0] sample_0;
	logic [7:0] sample_1;
	logic [7:0] sample_2;
	logic [7:0] sample_3;

	modport source (output valid, row_filter, sample_0, sample_1, sample_2, sample_3,
		input ready);
	modport sink (input valid, row_filter, sample_0, sample_1, sample_2, sample_3,
		output ready);
endinterface

interface pru_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       row_end;

	modport source (output valid, red, green, blue, alpha, row_end, input ready);
	modport sink (input valid, red, green, blue, alpha, row_end, output ready);
endinterface

@@ rtl/pru_lane.sv @@
// One channel lane: filter prediction (incl. Paeth) and modulo-256 add.
module pru_lane (
	input  pru_pkg::filt_t filt,
	input  pru_pkg::nbr_t  nbr,
	input  pru_pkg::byte_t raw,
	output pru_pkg::byte_t ch
);
	import pru_pkg::*;

	logic [8:0] sum_ab;
	logic [8:0] two_c;
	logic [7:0] pa;
	logic [7:0] pb;
	logic [8:0] pc;
	byte_t      paeth;
	byte_t      pred;

	always_comb begin
		sum_ab = {1'b0, nbr.left} + {1'b0, nbr.up};
		two_c  = {nbr.upleft, 1'b0};
		pa = (nbr.up > nbr.upleft) ? nbr.up - nbr.upleft : nbr.upleft - nbr.up;
		pb = (nbr.left > nbr.upleft) ? nbr.left - nbr.upleft : nbr.upleft - nbr.left;
		pc = (sum_ab > two_c) ? sum_ab - two_c : two_c - sum_ab;
		if (({1'b0, pa} <= pc) && (pa <= pb)) begin
			paeth = nbr.left;
		end else if ({1'b0, pb} <= pc) begin
			paeth = nbr.up;
		end else begin
			paeth = nbr.upleft;
		end
	end

	always_comb begin
		case (filt)
			FILT_SUB:   pred = nbr.left;
			FILT_UP:    pred = nbr.up;
			FILT_AVG:   pred = sum_ab[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = '0;
		endcase
	end

	assign ch = raw + pred;

endmodule

@@ rtl/pru_merge.sv @@
// Merges the four lane bytes into RGBA according to the colour mode.
module pru_merge (
	input  pru_pkg::pix_t  ch,
	input  pru_pkg::mode_t mode,
	output pru_pkg::byte_t red,
	output pru_pkg::byte_t green,
	output pru_pkg::byte_t blue,
	output pru_pkg::byte_t alpha
);
	import pru_pkg::*;

	always_comb begin
		case (mode)
			MODE_GRAY: begin
				red = ch[0]; green = ch[0]; blue = ch[0]; alpha = OPAQUE;
			end
			MODE_GRAY_ALPHA: begin
				red = ch[0]; green = ch[0]; blue = ch[0]; alpha = ch[1];
			end
			MODE_RGB: begin
				red = ch[0]; green = ch[1]; blue = ch[2]; alpha = OPAQUE;
			end
			default: begin
				red = ch[0]; green = ch[1]; blue = ch[2]; alpha = ch[3];
			end
		endcase
	end

endmodule

@@ rtl/png_row_unfilter_to_rgba_top.sv @@
// Top level: PNG row reconstruction (none/sub/up/average/Paeth) to RGBA pixels.
// Path: each input beat is registered in stage 1, passes the lanes and merge, and is registered in the output register.
// Throughput: one pixel per cycle while the output is not stalled; set by the left-pixel
// feedback through the four channel lanes, closed through the left_q register.
// Reset: control state (column, first-row flag, filter, neighbours, valids)
// clears at once; the line store is not cleared and needs no clearing pass.
module png_row_unfilter_to_rgba_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pru_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pru_pkg::CFG_DATA_W-1:0]     cfg_data,
	pru_in_if.sink                             filtered,
	pru_out_if.source                          rgba
);
	import pru_pkg::*;

	// configuration
	logic [WIDTH_W-1:0] image_width_q;
	mode_t              color_mode_q;

	// front end: row position, runs at accept time
	logic [ADDR_W-1:0]  col_q;
	logic               first_row_q;
	filt_t              active_filter_q;

	// stage 1: line store read data, lanes
	logic               valid_s1;
	pix_t               raw_s1;
	filt_t              filt_s1;
	logic [ADDR_W-1:0]  col_s1;
	logic               col_zero_s1;
	logic               first_s1;
	logic               last_s1;
	logic               fwd_s1;
	pix_t               up_mem_s1;

	// neighbour registers, updated as a pixel leaves stage 1
	pix_t               left_q;
	pix_t               upleft_q;

	// output register
	logic               out_valid_q;
	byte_t              red_q;
	byte_t              green_q;
	byte_t              blue_q;
	byte_t              alpha_q;
	logic               row_end_q;

	logic [ADDR_W-1:0]  mem_addr_wr;
	pix_t               line_mem [MAX_WIDTH];

	logic               accept;
	logic               adv_s1;
	logic [WIDTH_W-1:0] width_eff;
	logic               last_in;
	filt_t              filt_in;
	pix_t               up_s1;
	pix_t               left_s1;
	pix_t               upleft_s1;
	pix_t               ch_s1;
	byte_t              red_d;
	byte_t              green_d;
	byte_t              blue_d;
	byte_t              alpha_d;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_W'(1);
			color_mode_q  <= MODE_RGBA;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: image_width_q <= cfg_data[WIDTH_W-1:0];
				CFG_COLOR_MODE:  color_mode_q  <= mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	// stage 1 moves on whenever the output register is free or being drained,
	// so a new beat is taken in every cycle the downstream keeps up
	assign adv_s1         = valid_s1 && (!out_valid_q || rgba.ready);
	assign filtered.ready = !valid_s1 || adv_s1;
	assign accept         = filtered.valid && filtered.ready;

	// ---------------- row position ----------------
	// width 0 behaves as 1, anything past the line store depth as full depth
	always_comb begin
		if (image_width_q == '0) begin
			width_eff = WIDTH_W'(1);
		end else if (image_width_q > WIDTH_W'(MAX_WIDTH)) begin
			width_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			width_eff = image_width_q;
		end
		last_in = ({1'b0, col_q} + WIDTH_W'(1)) >= width_eff;
		if (col_q != '0) begin
			filt_in = active_filter_q;
		end else if (filtered.row_filter <= 8'(FILT_PAETH)) begin
			filt_in = filt_t'(filtered.row_filter[2:0]);
		end else begin
			filt_in = FILT_NONE;   // unknown filter type
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q           <= '0;
			first_row_q     <= 1'b1;
			active_filter_q <= FILT_NONE;
		end else if (accept) begin
			active_filter_q <= filt_in;
			if (last_in) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_q + ADDR_W'(1);
			end
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1      <= {filtered.sample_3, filtered.sample_2,
				filtered.sample_1, filtered.sample_0};
			filt_s1     <= filt_in;
			col_s1      <= col_q;
			col_zero_s1 <= (col_q == '0);
			first_s1    <= first_row_q;
			last_s1     <= last_in;
			// read and write of one address at the same edge: the pixel being
			// written is the one left_q takes, so pick it up from there
			fwd_s1      <= adv_s1 && (col_s1 == col_q);
		end
	end

	// line store: one write port (pixel leaving stage 1), one registered read
	assign mem_addr_wr = col_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			line_mem[mem_addr_wr] <= ch_s1;
		end
		if (accept) begin
			up_mem_s1 <= line_mem[col_q];
		end
	end

	// neighbours with the row and column edges zeroed and the line store bypass applied
	always_comb begin
		if (first_s1) begin
			up_s1 = '0;
		end else if (fwd_s1) begin
			up_s1 = left_q;
		end else begin
			up_s1 = up_mem_s1;
		end
		left_s1   = col_zero_s1 ? '0 : left_q;
		upleft_s1 = (col_zero_s1 || first_s1) ? '0 : upleft_q;
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		nbr_t nbr;
		assign nbr = '{left: left_s1[k], up: up_s1[k], upleft: upleft_s1[k]};
		pru_lane u_lane (
			.filt (filt_s1),
			.nbr  (nbr),
			.raw  (raw_s1[k]),
			.ch   (ch_s1[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (adv_s1) begin
			left_q   <= ch_s1;
			upleft_q <= up_s1;
		end
	end

	// ---------------- merge and output register ----------------
	pru_merge u_merge (
		.ch    (ch_s1),
		.mode  (color_mode_q),
		.red   (red_d),
		.green (green_d),
		.blue  (blue_d),
		.alpha (alpha_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rgba.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			red_q     <= red_d;
			green_q   <= green_d;
			blue_q    <= blue_d;
			alpha_q   <= alpha_d;
			row_end_q <= last_s1;
		end
	end

	assign rgba.valid   = out_valid_q;
	assign rgba.red     = red_q;
	assign rgba.green   = green_q;
	assign rgba.blue    = blue_q;
	assign rgba.alpha   = alpha_q;
	assign rgba.row_end = row_end_q;

	// ---------------- assertions ----------------
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("pixel left stage 1 but output register not loaded");

	a_fwd_only_col0: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1) |-> col_zero_s1)
		else $error("line store bypass taken away from column 0");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_in) |=> (col_q == '0))
		else $error("column did not wrap after last pixel of row");

	a_first_row_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_row_q) |-> $past(accept && last_in))
		else $error("first-row flag cleared without a row end");

endmodule
